// ===== rtl/bdvl_pkg.sv =====
// shared types and constants for the braking distance velocity limiter
package bdvl_pkg;

  typedef struct packed {
    logic signed [31:0] target_position;
    logic signed [31:0] measured_position;
    logic               position_valid;
    logic               trajectory_stale;
  } in_item_t;

  typedef struct packed {
    logic [30:0] command_velocity;
    logic        is_locked;
  } out_item_t;

  localparam logic [2:0] REG_BRAKE_GAIN = 3'd0;
  localparam logic [2:0] REG_CEILING    = 3'd1;
  localparam logic [2:0] REG_FLOOR      = 3'd2;
  localparam logic [2:0] REG_RAMP_UP    = 3'd3;
  localparam logic [2:0] REG_RAMP_DOWN  = 3'd4;
  localparam logic [2:0] REG_DEAD_IN    = 3'd5;
  localparam logic [2:0] REG_DEAD_OUT   = 3'd6;
  localparam logic [2:0] REG_ALPHA      = 3'd7;

  localparam logic [16:0] ALPHA_ONE   = 17'd65536;
  localparam logic [16:0] ALPHA_RESET = 17'd3875;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL   = 7'b0000010,
    ST_SQRT  = 7'b0000100,
    ST_LPF_A = 7'b0001000,
    ST_LPF_B = 7'b0010000,
    ST_SLEW  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

endpackage

// ===== rtl/braking_distance_velocity_limiter_unit.sv =====
// braking distance velocity limiter: error, lock, sqrt profile, low-pass and slew
// sequence from acceptance to the result transaction: one gain product, 32 square root
// steps, two filter multiplies, slew, then the output stage
// one transaction at a time: in_stall is high from acceptance until the result is
// taken, so no new item is accepted while one is in flight or held by out_stall
// reset: synchronous active low, clears state, lock flag and registers (alpha 3875)
module braking_distance_velocity_limiter_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bdvl_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bdvl_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_wdata
);

  logic [31:0] gain_r;
  logic [30:0] ceil_r, floor_r, up_r, down_r, din_r, dout_r;
  logic [16:0] alpha_r;
  logic signed [31:0] fv_r;
  logic lock_r;
  bdvl_pkg::state_t st_r;
  logic [4:0] cnt_r;
  logic neg_r, zero_r;
  logic [31:0] eabs_r;
  logic [63:0] rem_r;
  logic [63:0] num_r;
  logic [31:0] root_r;
  logic signed [49:0] acc_r;
  logic signed [32:0] vt_r;
  logic [30:0] cmd_r;

  // error, saturation and lock decision at acceptance
  logic signed [32:0] diff;
  logic signed [31:0] esat;
  logic [31:0] eabs;
  logic lock_nxt, zero_nxt;
  always_comb begin
    diff = in_data.position_valid ?
      (33'(in_data.target_position) - 33'(in_data.measured_position)) : 33'sd0;
    if (diff > 33'sh07FFFFFFF)       esat = 32'sh7FFFFFFF;
    else if (diff < -33'sh080000000) esat = 32'sh80000000;
    else                             esat = diff[31:0];
    eabs = esat[31] ? (32'd0 - 32'(esat)) : 32'(esat);
    lock_nxt = lock_r;
    zero_nxt = in_data.trajectory_stale;
    if (!in_data.trajectory_stale && din_r != 31'd0) begin
      if (eabs < {1'b0, din_r}) begin
        lock_nxt = 1'b1;
        zero_nxt = 1'b1;
      end else if (eabs > {1'b0, dout_r}) begin
        lock_nxt = 1'b0;
      end else if (lock_r) begin
        zero_nxt = 1'b1;
      end
    end
  end

  // one sqrt step: two bits of radicand a cycle
  logic [33:0] trial_rem, trial_sub;
  logic [65:0] rem_sh;
  always_comb begin
    rem_sh    = {rem_r, num_r[63:62]};
    trial_rem = rem_sh[33:0];
    trial_sub = {root_r, 2'b01};
  end

  // stop speed magnitude after floor and ceiling; sign travels in neg_r
  logic [31:0] v;
  always_comb begin
    v = root_r;
    if (v != 32'd0 && v < {1'b0, floor_r}) v = {1'b0, floor_r};
    if (v > {1'b0, ceil_r}) v = {1'b0, ceil_r};
  end

  logic [16:0] a_eff;
  assign a_eff = (alpha_r > bdvl_pkg::ALPHA_ONE) ? bdvl_pkg::ALPHA_ONE : alpha_r;

  // slew limit
  logic signed [33:0] delta, fsum;
  logic signed [31:0] fv_nxt;
  logic [31:0] fmag;
  always_comb begin
    delta = 34'(vt_r) - 34'(fv_r);
    if (delta > $signed({3'b0, up_r}))        delta = $signed({3'b0, up_r});
    else if (delta < -$signed({3'b0, down_r})) delta = -$signed({3'b0, down_r});
    fsum = 34'(fv_r) + delta;
    if (fsum > 34'sh07FFFFFFF)       fv_nxt = 32'sh7FFFFFFF;
    else if (fsum < -34'sh080000000) fv_nxt = 32'sh80000000;
    else                             fv_nxt = fsum[31:0];
    fmag = fv_nxt[31] ? (32'd0 - 32'(fv_nxt)) : 32'(fv_nxt);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0; ceil_r <= '0; floor_r <= '0; up_r <= '0; down_r <= '0;
      din_r <= '0; dout_r <= '0; alpha_r <= bdvl_pkg::ALPHA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bdvl_pkg::REG_BRAKE_GAIN: gain_r  <= cfg_wdata;
        bdvl_pkg::REG_CEILING:    ceil_r  <= cfg_wdata[30:0];
        bdvl_pkg::REG_FLOOR:      floor_r <= cfg_wdata[30:0];
        bdvl_pkg::REG_RAMP_UP:    up_r    <= cfg_wdata[30:0];
        bdvl_pkg::REG_RAMP_DOWN:  down_r  <= cfg_wdata[30:0];
        bdvl_pkg::REG_DEAD_IN:    din_r   <= cfg_wdata[30:0];
        bdvl_pkg::REG_DEAD_OUT:   dout_r  <= cfg_wdata[30:0];
        bdvl_pkg::REG_ALPHA:      alpha_r <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  // sequencer; the multiplier is shared by the gain product and both filter terms
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic mul_neg;
  always_comb begin
    mul_a = 32'd0; mul_b = 32'd0; mul_neg = 1'b0;
    unique case (st_r)
      bdvl_pkg::ST_MUL:   begin mul_a = gain_r; mul_b = eabs_r; end
      bdvl_pkg::ST_LPF_A: begin
        mul_a = {15'd0, a_eff}; mul_b = zero_r ? 32'd0 : v; mul_neg = neg_r;
      end
      bdvl_pkg::ST_LPF_B: begin
        mul_a = {15'd0, bdvl_pkg::ALPHA_ONE - a_eff};
        mul_b = fv_r[31] ? (32'd0 - 32'(fv_r)) : 32'(fv_r); mul_neg = fv_r[31];
      end
      default: ;
    endcase
    prod = {32'd0, mul_a} * {32'd0, mul_b};
  end

  logic signed [49:0] term, acc_sum;
  logic [49:0] acc_mag;
  always_comb begin
    term = mul_neg ? -$signed({1'b0, prod[48:0]}) : $signed({1'b0, prod[48:0]});
    acc_sum = acc_r + term;
    acc_mag = acc_sum[49] ? (50'd0 - 50'(acc_sum)) : 50'(acc_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= bdvl_pkg::ST_IDLE;
      fv_r <= '0;
      lock_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      unique case (st_r)
        bdvl_pkg::ST_IDLE: if (in_valid) begin
          eabs_r <= eabs; neg_r <= esat[31]; zero_r <= zero_nxt; lock_r <= lock_nxt;
          st_r <= bdvl_pkg::ST_MUL;
        end
        bdvl_pkg::ST_MUL: begin
          num_r <= prod; rem_r <= '0; root_r <= '0; cnt_r <= '0;
          st_r <= bdvl_pkg::ST_SQRT;
        end
        bdvl_pkg::ST_SQRT: begin
          num_r <= {num_r[61:0], 2'b00};
          if (trial_rem >= trial_sub) begin
            rem_r <= 64'(trial_rem - trial_sub); root_r <= {root_r[30:0], 1'b1};
          end else begin
            rem_r <= 64'(trial_rem); root_r <= {root_r[30:0], 1'b0};
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) st_r <= bdvl_pkg::ST_LPF_A;
        end
        bdvl_pkg::ST_LPF_A: begin
          acc_r <= term; st_r <= bdvl_pkg::ST_LPF_B;
        end
        bdvl_pkg::ST_LPF_B: begin
          vt_r <= acc_sum[49] ? -$signed({1'b0, acc_mag[47:16]})
                              : $signed({1'b0, acc_mag[47:16]});
          st_r <= bdvl_pkg::ST_SLEW;
        end
        bdvl_pkg::ST_SLEW: begin
          fv_r <= fv_nxt;
          cmd_r <= (fmag > {1'b0, ceil_r}) ? ceil_r : fmag[30:0];
          st_r <= bdvl_pkg::ST_OUT;
        end
        bdvl_pkg::ST_OUT: if (!out_stall) st_r <= bdvl_pkg::ST_IDLE;
        default: st_r <= bdvl_pkg::ST_IDLE;
      endcase
    end
  end

  assign in_stall = (st_r != bdvl_pkg::ST_IDLE);
  assign out_valid = (st_r == bdvl_pkg::ST_OUT);
  assign out_data.command_velocity = cmd_r;
  assign out_data.is_locked = lock_r;

  // checks
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("output shown while accepting");
  a_ceil: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.command_velocity <= ceil_r)) else $error("ceiling exceeded");
  a_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == bdvl_pkg::ST_SQRT) |=> (st_r == bdvl_pkg::ST_SQRT || st_r == bdvl_pkg::ST_LPF_A))
    else $error("sqrt loop left early");

endmodule

// ===== tb/sv/testbench.sv =====
// regression bench for the braking distance velocity limiter unit
`timescale 1ns / 1ps

module testbench;

  typedef logic [31:0] reg_set_t [8];

  typedef struct {
    bdvl_pkg::in_item_t  item;
    bdvl_pkg::out_item_t typed;
  } stim_row_t;

  localparam longint LIMIT_CYCLES = 1000000;
  localparam int     PHASE_ITEMS  = 125;
  localparam int     SETTLE       = 60;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  bdvl_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  bdvl_pkg::out_item_t out_data;
  logic                cfg_we;
  logic [2:0]          cfg_index;
  logic [31:0]         cfg_wdata;

  // predictor state and register copy
  longint m_gain, m_ceiling, m_floor, m_up, m_down, m_dead_in, m_dead_out, m_alpha;
  longint m_velocity;
  bit     m_locked;

  bdvl_pkg::out_item_t velocity_queue[$];
  int        error_count = 0;
  longint    cycle_count = 0;
  int        send_pct = 0;
  int        recv_pct = 0;

  braking_distance_velocity_limiter_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // rounded-down integer square root of a 64-bit value
  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r, t;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // advance the predictor by one tick and return the expected result
  function automatic bdvl_pkg::out_item_t predict_limit(bdvl_pkg::in_item_t it);
    longint tgt, meas, err, eabs, vt, a, s, q, delta, mag;
    longint unsigned v;
    bit hold;
    bdvl_pkg::out_item_t res;
    tgt  = longint'($signed(it.target_position));
    meas = it.position_valid ? longint'($signed(it.measured_position)) : tgt;
    vt   = 0;
    if (!it.trajectory_stale) begin
      err  = clamp(tgt - meas, -64'sh80000000, 64'sh7FFFFFFF);
      eabs = err < 0 ? -err : err;
      hold = 1'b0;
      // hysteretic deadband lock
      if (m_dead_in != 0) begin
        if (eabs < m_dead_in) begin
          m_locked = 1'b1;
          hold = 1'b1;
        end else if (eabs > m_dead_out) m_locked = 1'b0;
        else if (m_locked) hold = 1'b1;
      end
      if (!hold) begin
        v = root64(longint'(m_gain) * longint'(eabs));
        if (v > 0 && v < m_floor) v = m_floor;
        if (v > m_ceiling) v = m_ceiling;
        vt = err < 0 ? -longint'(v) : longint'(v);
      end
    end
    // low-pass, truncating toward zero
    a = m_alpha > 65536 ? 65536 : m_alpha;
    s = a * vt + (65536 - a) * m_velocity;
    q = (s < 0 ? -s : s) >>> 16;
    if (s < 0) q = -q;
    // slew limit
    delta = clamp(q - m_velocity, -m_down, m_up);
    m_velocity = clamp(m_velocity + delta, -64'sh80000000, 64'sh7FFFFFFF);
    mag = m_velocity < 0 ? -m_velocity : m_velocity;
    if (mag > m_ceiling) mag = m_ceiling;
    res.command_velocity = mag[30:0];
    res.is_locked = m_locked;
    return res;
  endfunction

  // write all eight registers, mirroring them into the predictor
  task automatic program_regs(reg_set_t r);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= r[i];
      case (3'(i))
        bdvl_pkg::REG_BRAKE_GAIN: m_gain     = r[i];
        bdvl_pkg::REG_CEILING:    m_ceiling  = r[i] & 32'h7FFFFFFF;
        bdvl_pkg::REG_FLOOR:      m_floor    = r[i] & 32'h7FFFFFFF;
        bdvl_pkg::REG_RAMP_UP:    m_up       = r[i] & 32'h7FFFFFFF;
        bdvl_pkg::REG_RAMP_DOWN:  m_down     = r[i] & 32'h7FFFFFFF;
        bdvl_pkg::REG_DEAD_IN:    m_dead_in  = r[i] & 32'h7FFFFFFF;
        bdvl_pkg::REG_DEAD_OUT:   m_dead_out = r[i] & 32'h7FFFFFFF;
        bdvl_pkg::REG_ALPHA:      m_alpha    = r[i] & 32'h1FFFF;
        default: ;
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // wait for all outstanding results, then let the pipeline drain
  task automatic drain();
    while (velocity_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // present one transaction, optionally idling first; returns on acceptance
  task automatic send_item(bdvl_pkg::in_item_t it, bit use_typed,
                           bdvl_pkg::out_item_t typed);
    bdvl_pkg::out_item_t pred;
    if ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    pred = predict_limit(it);
    velocity_queue = {velocity_queue, (use_typed ? typed : pred)};
  endtask

  function automatic bdvl_pkg::in_item_t random_item();
    bdvl_pkg::in_item_t it;
    int unsigned kind;
    int signed off;
    kind = $urandom_range(9);
    it.target_position = $urandom;
    off = $signed($urandom_range(0, (1 << $urandom_range(0, 20)))) *
          ($urandom_range(1) ? 1 : -1);
    if (kind <= 4) it.measured_position = it.target_position + off;
    else if (kind <= 6) it.measured_position = it.target_position + (off <<< 8);
    else if (kind == 7) it.measured_position = $urandom;
    else begin
      it.target_position   = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      it.measured_position = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
    end
    it.position_valid   = $urandom_range(9) != 0;
    it.trajectory_stale = $urandom_range(9) == 0;
    return it;
  endfunction

  function automatic reg_set_t random_regs();
    reg_set_t r;
    r[bdvl_pkg::REG_BRAKE_GAIN] = $urandom_range(1) ? $urandom : $urandom_range(0, 1 << 22);
    r[bdvl_pkg::REG_CEILING]    = ($urandom & 32'h7FFFFFFF) >> $urandom_range(0, 14);
    r[bdvl_pkg::REG_FLOOR]      = ($urandom & 32'h7FFFFFFF) >> $urandom_range(6, 20);
    r[bdvl_pkg::REG_RAMP_UP]    = ($urandom & 32'h7FFFFFFF) >> $urandom_range(0, 18);
    r[bdvl_pkg::REG_RAMP_DOWN]  = ($urandom & 32'h7FFFFFFF) >> $urandom_range(0, 18);
    r[bdvl_pkg::REG_DEAD_IN]    = $urandom_range(2) == 0 ? 0 : $urandom_range(0, 1 << 18);
    r[bdvl_pkg::REG_DEAD_OUT]   = r[bdvl_pkg::REG_DEAD_IN] + $urandom_range(0, 1 << 18);
    r[bdvl_pkg::REG_ALPHA]      = $urandom_range(9) == 0 ? $urandom_range(65536, 131071)
                                                         : $urandom_range(0, 65536);
    return r;
  endfunction

  // receiver back-pressure
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_pct);

  // result checker
  always @(posedge clk) begin
    bdvl_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (velocity_queue.size() == 0) begin
        $error("unexpected transaction: command_velocity %0h is_locked %0b",
               out_data.command_velocity, out_data.is_locked);
        error_count++;
      end else begin
        want = velocity_queue.pop_front();
        if (out_data.command_velocity !== want.command_velocity) begin
          $error("command_velocity expected %0h actual %0h",
                 want.command_velocity, out_data.command_velocity);
          error_count++;
        end
        if (out_data.is_locked !== want.is_locked) begin
          $error("is_locked expected %0b actual %0b", want.is_locked, out_data.is_locked);
          error_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("braking_distance_velocity_limiter_unit regression: fail");
      $finish;
    end
  end

  initial begin
    stim_row_t          table_rows[$];
    reg_set_t           rs;
    bdvl_pkg::in_item_t it;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= bdvl_pkg::REG_BRAKE_GAIN;
    cfg_wdata <= '0;
    m_gain = 0; m_ceiling = 0; m_floor = 0; m_up = 0; m_down = 0;
    m_dead_in = 0; m_dead_out = 0; m_alpha = bdvl_pkg::ALPHA_RESET;
    m_velocity = 0; m_locked = 1'b0;

    // directed rows: zero ceiling after reset means every result is zero
    table_rows = '{
      '{'{32'h7FFFFFFF, 32'h80000000, 1'b1, 1'b0}, '0},  // error saturates high
      '{'{32'h80000000, 32'h7FFFFFFF, 1'b1, 1'b0}, '0},  // error saturates low
      '{'{32'h00010000, 32'h00010000, 1'b1, 1'b0}, '0},  // zero error
      '{'{32'h00012000, 32'h00010000, 1'b1, 1'b0}, '0},  // inside deadband
      '{'{32'h00014000, 32'h00010000, 1'b1, 1'b0}, '0},  // between the bands
      '{'{32'h00050000, 32'h00010000, 1'b1, 1'b1}, '0},  // stale keeps the lock
      '{'{32'h00050000, 32'h00010000, 1'b1, 1'b0}, '0},  // releases the lock
      '{'{32'h00014000, 32'h00010000, 1'b1, 1'b0}, '0},  // between, unlocked
      '{'{32'h12345678, 32'hFFFFFFFF, 1'b0, 1'b0}, '0},  // missing reading
      '{'{32'hFFFF0000, 32'h00100000, 1'b1, 1'b0}, '0},  // negative error
      '{'{32'h00000001, 32'h00000000, 1'b1, 1'b0}, '0},  // tiny error, floor
      '{'{32'h00000000, 32'h00000001, 1'b1, 1'b0}, '0},
      '{'{32'h7FFFFFFF, 32'h00000000, 1'b1, 1'b1}, '0},  // stale, decay
      '{'{32'h7FFFFFFF, 32'h00000000, 1'b0, 1'b1}, '0},
      '{'{32'h80000000, 32'h00000000, 1'b1, 1'b0}, '0},
      '{'{32'h00000000, 32'h80000000, 1'b1, 1'b0}, '0}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pass at reset values, typed expectations
    foreach (table_rows[i]) send_item(table_rows[i].item, 1'b1, table_rows[i].typed);
    in_valid <= 1'b0;
    drain();

    // directed pass with locking and floor above ceiling, predicted
    rs = '{32'h00400000, 32'h00030000, 32'h00040000, 32'h00008000,
           32'h00010000, 32'h00003000, 32'h00020000, 32'h00008000};
    program_regs(rs);
    foreach (table_rows[i]) send_item(table_rows[i].item, 1'b0, '0);
    in_valid <= 1'b0;
    drain();

    // random part over three idling modes and several settings each
    for (int mode = 0; mode < 3; mode++) begin
      send_pct = mode == 0 ? 6 : (mode == 1 ? 65 : 0);
      recv_pct = mode == 0 ? 65 : (mode == 1 ? 6 : 0);
      for (int k = 0; k < 3; k++) begin
        if (mode == 0 && k == 0)
          rs = '{32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0001FFFF};
        else if (mode == 1 && k == 0)
          rs = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
        else if (mode == 2 && k == 0)
          rs = '{32'hFFFFFFFF, 32'h7FFFFFFF, 32'h0, 32'h7FFFFFFF,
                 32'h7FFFFFFF, 32'h0, 32'h0, 32'h00010000};
        else rs = random_regs();
        program_regs(rs);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
          if (mode == 0 && k == 1 && n == PHASE_ITEMS / 2) begin
            in_valid <= 1'b0;
            while (velocity_queue.size() != 0) @(posedge clk);
          end
          it = random_item();
          send_item(it, 1'b0, '0);
        end
        in_valid <= 1'b0;
        drain();
      end
    end

    if (error_count == 0) $display("braking_distance_velocity_limiter_unit regression: pass");
    else $display("braking_distance_velocity_limiter_unit regression: fail");
    $finish;
  end

endmodule
